### rtl/csd_pkg.sv
// Shared types and constants for the corner set stability detector.
// Used by csd_ctrl, csd_datapath and corner_set_stability_detector. No dependencies.
package csd_pkg;

    localparam int COORD_W   = 13;
    localparam int CORNER_W  = 4 * COORD_W;
    localparam int SUM_W     = 24;
    localparam int DIFF_W    = COORD_W + 2;
    localparam int FRAC_BITS = 4;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0] THRESH_RESET = SUM_W'(1000 << FRAC_BITS);

    typedef struct packed {
        logic capture;
        logic read;
        logic write;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pos_ok;
        logic full;
        logic last;
        logic read_last;
        logic pipe_busy;
        logic out_free;
    } ctrl_status_t;

endpackage

### rtl/corner_set_stability_detector.sv
// Corner set stability detector, top level: stream ports, APB threshold register,
// controller and datapath. Depends on csd_pkg, csd_ctrl and csd_datapath.
//
// Usage:
//   s_ channel: one stereo corner pair per request, s_tlast on the last corner of a frame.
//   m_ channel: one result per frame, given on the request that carries s_tlast.
//   APB: register 0 (byte address 0) is stable_threshold, 24 bits, reset 16000.
// Throughput: one corner at a time. A corner taken while the window is full is followed
//   by FRAMES memory reads on the single read port, a difference pipeline drain, store
//   and close; one taken while filling by store and close; a corner beyond CORNERS in
//   its frame by close alone.
// Latency: the result is valid the cycle after the closing step of the frame.
// Reset: window empty, counters and sum cleared, threshold at 16000; memory contents
//   are not cleared, and a read can reach a position that no frame has written since reset.
// Stall: the result sits in an output register while further corners are taken;
//   only a frame close waits for that register to free.
module corner_set_stability_detector #(
    parameter int FRAMES  = 10,
    parameter int CORNERS = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // left_x, left_y, right_x, right_y, 4'b0 pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // difference_sum
    output logic [1:0]  m_tuser,   // stable, filling
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_THRESHOLD = 1'b0;

    logic [csd_pkg::SUM_W-1:0] thr_reg;
    csd_pkg::ctrl_cmd_t        cmd;
    csd_pkg::ctrl_status_t     status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(thr_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= csd_pkg::THRESH_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
            thr_reg <= pwdata[csd_pkg::SUM_W-1:0];
        end
    end

    csd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    csd_datapath #(
        .FRAMES  (FRAMES),
        .CORNERS (CORNERS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .threshold (thr_reg),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second corner taken while one is in progress");

    a_finish_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.last && status.out_free)
        else $error("frame close without last corner or free output");

    a_read_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.read |-> status.full && status.pos_ok)
        else $error("window read while filling or past corner count");

    a_stable_not_filling: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("stable reported on a filling frame");

endmodule

### rtl/csd_ctrl.sv
// Sequencer for the corner set stability detector: accept, window reads, drain,
// store and frame close. Depends on csd_pkg for the command and status structs.
module csd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  csd_pkg::ctrl_status_t status,
    output csd_pkg::ctrl_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (!status.pos_ok) begin
                        state_next = ST_FINISH;
                    end else if (status.full) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_READ: begin
                cmd.read = 1'b1;
                if (status.read_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!status.last) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/csd_datapath.sv
// Datapath: corner window memory, difference pipeline, frame counters and result register.
// Depends on csd_pkg; driven by csd_ctrl through ctrl_cmd_t.
module csd_datapath #(
    parameter int FRAMES  = 10,
    parameter int CORNERS = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [55:0]                   s_tdata,
    input  logic                          s_tlast,
    input  logic [csd_pkg::SUM_W-1:0]     threshold,
    input  csd_pkg::ctrl_cmd_t            cmd,
    output csd_pkg::ctrl_status_t         status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,
    output logic [1:0]                    m_tuser
);

    localparam int SW    = $clog2(FRAMES);
    localparam int HW    = $clog2(FRAMES + 1);
    localparam int PW    = $clog2(CORNERS);
    localparam int POSW  = $clog2(CORNERS + 1);
    localparam int DEPTH = 1 << (SW + PW);
    localparam int CW    = csd_pkg::COORD_W;
    localparam int SUMW  = csd_pkg::SUM_W;
    localparam int DW    = csd_pkg::DIFF_W;

    logic [csd_pkg::CORNER_W-1:0] mem [DEPTH];

    logic [csd_pkg::CORNER_W-1:0] corner_reg;
    logic                         last_reg;
    logic [HW-1:0]                held_reg;
    logic [SW-1:0]                ws_reg;
    logic [POSW-1:0]              pos_reg;
    logic [SUMW-1:0]              acc_reg;
    logic [SW-1:0]                rd_idx_reg;
    logic [csd_pkg::CORNER_W-1:0] rdata_reg;
    logic                         rd_valid_reg;
    logic [DW-1:0]                diff_reg;
    logic                         diff_valid_reg;
    logic                         out_valid_reg;
    logic                         out_stable_reg;
    logic                         out_filling_reg;
    logic [SUMW-1:0]              out_sum_reg;

    logic            full;
    logic [SW-1:0]   slot;
    logic [DW-1:0]   diff_next;
    logic [SUMW:0]   acc_sum;
    logic            out_free;
    logic            is_stable;

    assign full     = (held_reg >= HW'(FRAMES));
    assign slot     = full ? ws_reg : SW'(held_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign is_stable = (acc_reg < threshold);

    assign status.pos_ok    = (pos_reg < POSW'(CORNERS));
    assign status.full      = full;
    assign status.last      = last_reg;
    assign status.read_last = (rd_idx_reg == SW'(FRAMES - 1));
    assign status.pipe_busy = rd_valid_reg || diff_valid_reg;
    assign status.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[{slot, pos_reg[PW-1:0]}] <= corner_reg;
        end
        if (cmd.read) begin
            rdata_reg <= mem[{rd_idx_reg, pos_reg[PW-1:0]}];
        end
    end

    always_comb begin
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        diff_next = '0;
        for (int k = 0; k < 4; k++) begin
            a = corner_reg[k*CW +: CW];
            b = rdata_reg[k*CW +: CW];
            diff_next = diff_next + DW'(a > b ? a - b : b - a);
        end
    end

    assign acc_sum = {1'b0, acc_reg} + (SUMW + 1)'(diff_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            corner_reg <= s_tdata[csd_pkg::CORNER_W-1:0];
        end
        if (rd_valid_reg) begin
            diff_reg <= diff_next;
        end
        if (cmd.finish) begin
            out_stable_reg  <= full && is_stable;
            out_filling_reg <= !full;
            out_sum_reg     <= full ? acc_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg       <= 1'b0;
            held_reg       <= '0;
            ws_reg         <= '0;
            pos_reg        <= '0;
            acc_reg        <= '0;
            rd_idx_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            diff_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.capture) begin
                last_reg   <= s_tlast;
                rd_idx_reg <= '0;
            end else if (cmd.read) begin
                rd_idx_reg <= rd_idx_reg + SW'(1);
            end
            // the slot about to be overwritten holds the oldest frame, skip it
            rd_valid_reg   <= cmd.read && (rd_idx_reg != slot);
            diff_valid_reg <= rd_valid_reg;
            if (diff_valid_reg) begin
                acc_reg <= acc_sum[SUMW] ? csd_pkg::SUM_MAX : acc_sum[SUMW-1:0];
            end
            if (cmd.write) begin
                pos_reg <= pos_reg + POSW'(1);
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
                acc_reg       <= '0;
                pos_reg       <= '0;
                if (!full) begin
                    held_reg <= held_reg + HW'(1);
                end else if (is_stable) begin
                    held_reg <= '0;
                    ws_reg   <= '0;
                end else begin
                    ws_reg <= (ws_reg == SW'(FRAMES - 1)) ? '0 : ws_reg + SW'(1);
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tuser  = {out_filling_reg, out_stable_reg};

endmodule
